// File: hdl/palette_map_fs_dither_macros.svh
// Assertion macros shared by the palette mapper RTL.
`ifndef PALETTE_MAP_FS_DITHER_MACROS_SVH
`define PALETTE_MAP_FS_DITHER_MACROS_SVH
`ifndef ASSERT_OFF
`define PMFD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define PMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PMFD_ASSERT(lbl, expr, msg)
`define PMFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/pmfd_pkg.sv
// Shared types, constants and functions of the palette mapper.
`timescale 1ns / 1ps
package pmfd_pkg;
  localparam int MAX_WIDTH    = 1024;
  localparam int PALETTE_SIZE = 256;
  localparam int ERR_W        = 20;
  localparam int TAG_W        = 16;
  localparam int ERR_AW       = 12;
  localparam int DIST_W       = 18;

  localparam logic [10:0] WIDTH_MAX = 11'(MAX_WIDTH);
  localparam logic [8:0]  COUNT_MAX = 9'(PALETTE_SIZE);

  // order of the four read-modify-write updates of the error rows
  localparam logic [1:0] UPD_AHEAD_CUR = 2'd0;
  localparam logic [1:0] UPD_BEHIND    = 2'd1;
  localparam logic [1:0] UPD_BELOW     = 2'd2;
  localparam logic [1:0] UPD_AHEAD_NXT = 2'd3;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [3:0] err4_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    err4_t            err;
  } err_word_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ERR_AW-1:0] addr;
    logic [TAG_W-1:0]  tag;
  } err_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  index;
    logic [31:0] entry;
  } srch_res_t;

  // error share per update, already scaled by 1024/16
  function automatic logic [9:0] upd_weight(input logic [1:0] k);
    logic [9:0] w;
    unique case (k)
      UPD_AHEAD_CUR: w = 10'd448;
      UPD_BEHIND:    w = 10'd192;
      UPD_BELOW:     w = 10'd320;
      UPD_AHEAD_NXT: w = 10'd64;
      default:       w = 10'd0;
    endcase
    return w;
  endfunction
endpackage

// File: hdl/pmfd_err_store.sv
// Error row memory with an epoch tag per word; stale words read as zero.
`timescale 1ns / 1ps
module pmfd_err_store import pmfd_pkg::*; (
  input  logic     clk,
  input  err_req_t req,
  input  err4_t    wr_data,
  output err4_t    rd_data
);
  err_word_t        mem [0:(1 << ERR_AW) - 1];
  err_word_t        rd_q;
  logic [TAG_W-1:0] tag_q;

  // write or read the single port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= {req.tag, wr_data};
    end
    if (req.rd_en) begin
      rd_q  <= mem[req.addr];
      tag_q <= req.tag;
    end
  end

  // drop words written in an older row
  assign rd_data = (rd_q.tag == tag_q) ? rd_q.err : '0;
endmodule

// File: hdl/pmfd_search.sv
// Palette memory and the shared distance unit that scans it one entry a cycle.
`timescale 1ns / 1ps
module pmfd_search import pmfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pal_wr,
  input  logic [7:0]  pal_idx,
  input  logic [31:0] pal_data,
  input  logic        start,
  input  logic [7:0]  count_last,
  input  logic [31:0] ch_in,
  output srch_res_t   res
);
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SCAN  = 2'd1;
  localparam logic [1:0] PH_FETCH = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [31:0]       pal_mem [0:PALETTE_SIZE-1];
  logic [31:0]       rd_q;
  logic [1:0]        phase;
  logic              issue_on;
  logic [7:0]        issue_i;
  logic              rd_v;
  logic [7:0]        rd_idx;
  logic              dist_v;
  logic [7:0]        dist_idx;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] best_d;
  logic [7:0]        best_i;
  logic [7:0]        rd_addr;
  logic              rd_en;
  logic [DIST_W-1:0] dist_sum;

  assign rd_en   = ((phase == PH_SCAN) && issue_on) || (phase == PH_FETCH);
  assign rd_addr = (phase == PH_SCAN) ? issue_i : best_i;

  // palette writes and registered reads
  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[pal_idx] <= pal_data;
    end
    if (rd_en) begin
      rd_q <= pal_mem[rd_addr];
    end
  end

  // squared distance over the four channels
  always_comb begin
    logic signed [8:0]  diff;
    logic        [17:0] sq;
    dist_sum = '0;
    for (int c = 0; c < 4; c++) begin
      diff     = $signed({1'b0, ch_in[8*c +: 8]}) - $signed({1'b0, rd_q[8*c +: 8]});
      sq       = 18'(diff * diff);
      dist_sum = dist_sum + sq;
    end
  end

  // issue, measure and compare; then fetch the winner
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      issue_on <= 1'b0;
      rd_v     <= 1'b0;
      dist_v   <= 1'b0;
    end else begin
      rd_v     <= (phase == PH_SCAN) && issue_on;
      rd_idx   <= issue_i;
      dist_v   <= rd_v;
      dist_idx <= rd_idx;
      dist_q   <= dist_sum;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase    <= PH_SCAN;
            issue_on <= 1'b1;
            issue_i  <= '0;
            best_d   <= '1;
            best_i   <= '0;
          end
        end
        PH_SCAN: begin
          if (issue_on) begin
            issue_i <= issue_i + 8'd1;
            if (issue_i == count_last) begin
              issue_on <= 1'b0;
            end
          end
          if (dist_v && (dist_q < best_d)) begin
            best_d <= dist_q;
            best_i <= dist_idx;
          end
          if (!issue_on && !rd_v && !dist_v) begin
            phase <= PH_FETCH;
          end
        end
        PH_FETCH: phase <= PH_DONE;
        PH_DONE:  phase <= PH_IDLE;
        default:  phase <= PH_IDLE;
      endcase
    end
  end

  assign res.done  = (phase == PH_DONE);
  assign res.index = best_i;
  assign res.entry = rd_q;
endmodule

// File: hdl/palette_map_fs_dither.sv
// Top level: sequencer for nearest-palette mapping with serpentine error diffusion.
// Palette write: accepted while idle. Pixel (n = effective palette count): the carried
// error is added, the search scans n entries, then with dithering on four error updates follow.
// The scan of one distance unit runs at one entry per cycle, and each of the four error
// updates is a read-modify-write; a stalled result holds the next pixel back.
// Reset: error memory sweep of all 4096 words, column 0, forward scan, registers at defaults.
`timescale 1ns / 1ps
`include "palette_map_fs_dither_macros.svh"
module palette_map_fs_dither import pmfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  entry_index,
  input  logic        start_of_image,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic [7:0]  pixel_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  color_index
);
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_LEVEL     = 2'd2;
  localparam logic [1:0] REG_DITHER_ENABLE = 2'd3;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PREP   = 4'd2;
  localparam logic [3:0] ST_RDERR  = 4'd3;
  localparam logic [3:0] ST_CORR   = 4'd4;
  localparam logic [3:0] ST_GO     = 4'd5;
  localparam logic [3:0] ST_SEARCH = 4'd6;
  localparam logic [3:0] ST_UPD_RD = 4'd7;
  localparam logic [3:0] ST_UPD_WR = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [10:0]       image_width;
  logic [8:0]        palette_count;
  logic [7:0]        max_level;
  logic              dither_enable;
  logic [3:0]        state;
  logic [ERR_AW-1:0] clr_addr;
  logic [9:0]        col_pos;
  logic              scan_fwd;
  logic [TAG_W-1:0]  epoch;
  logic [9:0]        col;
  logic              dith;
  logic              fwd;
  logic [3:0][7:0]   pix;
  logic [3:0][7:0]   ch_q;
  logic signed [8:0] diff_q [4];
  logic [1:0]        upd;
  logic [7:0]        best;

  logic [10:0]       w_eff;
  logic [10:0]       w_m1;
  logic [9:0]        w_last;
  logic [8:0]        n_eff;
  logic [8:0]        n_m1;
  logic [9:0]        cp_sat;
  logic              prep_fwd;
  logic [9:0]        prep_col;
  logic [10:0]       col_mid;
  logic [10:0]       col_ahead;
  logic [10:0]       col_behind;
  logic [10:0]       cp_inc;
  logic [ERR_AW-1:0] upd_addr;
  logic [TAG_W-1:0]  upd_tag;
  logic [3:0][7:0]   ch_corr;
  err4_t             err_rd;
  err4_t             err_wr;
  err_req_t          err_req;
  srch_res_t         srch_res;
  logic              in_take;
  logic              pal_wr;
  logic              out_free;

  // effective width and palette count
  always_comb begin
    w_eff = (image_width == 11'd0) ? 11'd1 :
            ((image_width > WIDTH_MAX) ? WIDTH_MAX : image_width);
    w_m1   = w_eff - 11'd1;
    w_last = w_m1[9:0];
    n_eff = (palette_count == 9'd0) ? 9'd1 :
            ((palette_count > COUNT_MAX) ? COUNT_MAX : palette_count);
    n_m1  = n_eff - 9'd1;
  end

  // column of this pixel
  always_comb begin
    cp_sat     = ({1'b0, col_pos} >= w_eff) ? w_last : col_pos;
    prep_fwd   = !dither_enable || scan_fwd;
    prep_col   = prep_fwd ? cp_sat : (w_last - cp_sat);
    col_mid    = {1'b0, col} + 11'd1;
    col_ahead  = fwd ? ({1'b0, col} + 11'd2) : {1'b0, col};
    col_behind = fwd ? {1'b0, col} : ({1'b0, col} + 11'd2);
    cp_inc     = {1'b0, col_pos} + 11'd1;
  end

  // address and tag of the current update
  always_comb begin
    unique case (upd)
      UPD_AHEAD_CUR: begin
        upd_addr = {epoch[0], col_ahead};
        upd_tag  = epoch;
      end
      UPD_BEHIND: begin
        upd_addr = {~epoch[0], col_behind};
        upd_tag  = epoch + 16'd1;
      end
      UPD_BELOW: begin
        upd_addr = {~epoch[0], col_mid};
        upd_tag  = epoch + 16'd1;
      end
      default: begin
        upd_addr = {~epoch[0], col_ahead};
        upd_tag  = epoch + 16'd1;
      end
    endcase
  end

  // error memory port
  always_comb begin
    err_req.wr_en = (state == ST_CLR) || (state == ST_UPD_WR);
    err_req.rd_en = (state == ST_RDERR) || (state == ST_UPD_RD);
    if (state == ST_CLR) begin
      err_req.addr = clr_addr;
      err_req.tag  = '0;
    end else if (state == ST_RDERR) begin
      err_req.addr = {epoch[0], col_mid};
      err_req.tag  = epoch;
    end else begin
      err_req.addr = upd_addr;
      err_req.tag  = upd_tag;
    end
  end

  // accumulate a share of the quantization error
  always_comb begin
    logic signed [10:0] wgt;
    logic signed [19:0] prod;
    wgt = $signed({1'b0, upd_weight(upd)});
    for (int c = 0; c < 4; c++) begin
      prod      = 20'(diff_q[c] * wgt);
      err_wr[c] = (state == ST_CLR) ? '0 : 20'($signed(err_rd[c]) + prod);
    end
  end

  // with dithering on, add carried error, truncate toward zero, clamp; else pass the pixel
  always_comb begin
    logic signed [19:0] e;
    logic signed [19:0] eb;
    logic signed [10:0] s;
    for (int c = 0; c < 4; c++) begin
      e  = $signed(err_rd[c]);
      eb = e + (e[19] ? 20'sd1023 : 20'sd0);
      s  = $signed({3'b000, pix[c]}) + $signed({eb[19], eb[19:10]});
      if (!dith) begin
        ch_corr[c] = pix[c];
      end else if (s[10]) begin
        ch_corr[c] = 8'd0;
      end else if (s > $signed({3'b000, max_level})) begin
        ch_corr[c] = max_level;
      end else begin
        ch_corr[c] = s[7:0];
      end
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign pal_wr   = in_take && !action;
  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd1024;
      palette_count <= 9'd256;
      max_level     <= 8'd255;
      dither_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_PALETTE_COUNT: palette_count <= cfg_data[8:0];
        REG_MAX_LEVEL:     max_level     <= cfg_data[7:0];
        REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      col_pos   <= '0;
      scan_fwd  <= 1'b1;
      epoch     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop an accepted result unless a new one is loaded below
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 12'd1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take && action) begin
            pix   <= {pixel_alpha, pixel_blue, pixel_green, pixel_red};
            state <= ST_PREP;
            if (start_of_image) begin
              epoch    <= epoch + 16'd2;
              col_pos  <= '0;
              scan_fwd <= 1'b1;
            end
          end
        end
        ST_PREP: begin
          col_pos <= cp_sat;
          col     <= prep_col;
          fwd     <= prep_fwd;
          dith    <= dither_enable;
          state   <= ST_RDERR;
        end
        ST_RDERR: state <= ST_CORR;
        ST_CORR: begin
          ch_q  <= ch_corr;
          state <= ST_GO;
        end
        ST_GO: state <= ST_SEARCH;
        ST_SEARCH: begin
          if (srch_res.done) begin
            best <= srch_res.index;
            for (int c = 0; c < 4; c++) begin
              diff_q[c] <= $signed({1'b0, ch_q[c]}) - $signed({1'b0, srch_res.entry[8*c +: 8]});
            end
            upd   <= UPD_AHEAD_CUR;
            state <= dith ? ST_UPD_RD : ST_DONE;
          end
        end
        ST_UPD_RD: state <= ST_UPD_WR;
        ST_UPD_WR: begin
          upd   <= upd + 2'd1;
          state <= (upd == UPD_AHEAD_NXT) ? ST_DONE : ST_UPD_RD;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            color_index <= best;
            state       <= ST_IDLE;
            if (cp_inc >= w_eff) begin
              col_pos <= '0;
              if (dith) begin
                epoch    <= epoch + 16'd1;
                scan_fwd <= !scan_fwd;
              end
            end else begin
              col_pos <= cp_inc[9:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pmfd_err_store u_err_store (
    .clk     (clk),
    .req     (err_req),
    .wr_data (err_wr),
    .rd_data (err_rd)
  );

  pmfd_search u_search (
    .clk        (clk),
    .rst        (rst),
    .pal_wr     (pal_wr),
    .pal_idx    (entry_index),
    .pal_data   ({pixel_alpha, pixel_blue, pixel_green, pixel_red}),
    .start      (state == ST_GO),
    .count_last (n_m1[7:0]),
    .ch_in      (ch_q),
    .res        (srch_res)
  );

  `PMFD_ASSERT(a_done_in_search, !srch_res.done || (state == ST_SEARCH), "search result outside search")
  `PMFD_ASSERT(a_err_wr_state, !err_req.wr_en || (state == ST_CLR) || (state == ST_UPD_WR), "stray error write")
  `PMFD_ASSERT_NEXT(a_pixel_starts, in_valid && !in_stall && action, state == ST_PREP, "pixel beat not started")
  `PMFD_ASSERT_NEXT(a_result_loaded, (state == ST_DONE) && out_free, out_valid && (state == ST_IDLE), "result not loaded")
endmodule
